// ----- design/sst_pkg.sv -----
package sst_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_DECIDE,
        ST_INS_RD,
        ST_INS_WR,
        ST_REM_RD,
        ST_REM_WR,
        ST_FINISH
    } t_state;

endpackage

// ----- design/sorted_set_table.sv -----
// Sorted set of distinct keys, held in ascending order in a single-port-write,
// single-port-read memory of sst_pkg::CAPACITY entries.
// Request channel: i_valid / o_stall carrying i_op and i_key. An item is taken
// on a rising edge with i_valid high and o_stall low. Op 0 inserts, 1 removes,
// 2 tests for presence, and 3 does nothing.
// Result channel: o_valid / i_stall carrying o_success, o_table_full and
// o_entry_count, one result item per request.
// One request is worked on at a time, and o_stall stays high until its result
// has been moved into the output register. A shared comparator scans the memory
// from entry 0, reading each entry in ST_SEARCH and comparing the registered
// read data in ST_CMP, until it finds the first key not below the request key.
// Insert and remove then move the tail of the table by one place, with a read
// state and a write state for each moved entry. A new item is taken only after
// the result of the last one is registered.
// A result that the receiver stalls stays in the output register. The block
// still takes the next item and works on it, holding its result back until
// the register is free.
// Reset empties the set at once; the memory itself is never cleared, since
// only entries below the entry count are ever read.
module sorted_set_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_op,
    input  logic [sst_pkg::KEY_BITS-1:0] i_key,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_success,
    output logic                         o_table_full,
    output logic [sst_pkg::CNT_W-1:0]    o_entry_count
);

    localparam int IW = sst_pkg::IDX_W;
    localparam int CW = sst_pkg::CNT_W;
    localparam int KW = sst_pkg::KEY_BITS;

    logic [KW-1:0] mem [sst_pkg::CAPACITY];

    sst_pkg::t_state r_state, n_state;
    sst_pkg::t_op    r_op,    n_op;
    logic [KW-1:0]   r_key,   n_key;
    logic [CW-1:0]   r_idx,   n_idx;
    logic [IW-1:0]   r_sh,    n_sh;
    logic [CW-1:0]   r_count, n_count;
    logic            r_present, n_present;
    logic            r_ok,    n_ok;
    logic            r_full,  n_full;
    logic [KW-1:0]   r_rd_data;

    logic            r_out_valid, n_out_valid;
    logic            r_out_ok,    n_out_ok;
    logic            r_out_full,  n_out_full;
    logic [CW-1:0]   r_out_count, n_out_count;

    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [KW-1:0]   wr_data;

    logic            accept;
    logic            out_free;
    logic            key_lt;
    logic            key_eq;
    logic            table_at_cap;
    logic            rem_last;

    assign accept       = (r_state == sst_pkg::ST_IDLE) && i_valid;
    assign out_free     = !r_out_valid || !i_stall;
    assign key_lt       = r_rd_data < r_key;
    assign key_eq       = r_rd_data == r_key;
    assign table_at_cap = r_count == CW'(sst_pkg::CAPACITY);
    assign rem_last     = ({1'b0, r_sh} + CW'(1)) >= r_count;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sst_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = sst_pkg::ST_SEARCH;
                end
            end
            sst_pkg::ST_SEARCH: begin
                if (r_idx == r_count) begin
                    n_state = sst_pkg::ST_DECIDE;
                end else begin
                    n_state = sst_pkg::ST_CMP;
                end
            end
            sst_pkg::ST_CMP: begin
                if (key_lt) begin
                    n_state = sst_pkg::ST_SEARCH;
                end else begin
                    n_state = sst_pkg::ST_DECIDE;
                end
            end
            sst_pkg::ST_DECIDE: begin
                n_state = sst_pkg::ST_FINISH;
                if (r_op == sst_pkg::OP_INSERT && !r_present && !table_at_cap) begin
                    n_state = sst_pkg::ST_INS_RD;
                end else if (r_op == sst_pkg::OP_REMOVE && r_present) begin
                    n_state = sst_pkg::ST_REM_RD;
                end
            end
            sst_pkg::ST_INS_RD: begin
                if (r_sh == r_idx[IW-1:0]) begin
                    n_state = sst_pkg::ST_FINISH;
                end else begin
                    n_state = sst_pkg::ST_INS_WR;
                end
            end
            sst_pkg::ST_INS_WR: begin
                n_state = sst_pkg::ST_INS_RD;
            end
            sst_pkg::ST_REM_RD: begin
                if (rem_last) begin
                    n_state = sst_pkg::ST_FINISH;
                end else begin
                    n_state = sst_pkg::ST_REM_WR;
                end
            end
            sst_pkg::ST_REM_WR: begin
                n_state = sst_pkg::ST_REM_RD;
            end
            sst_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = sst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sst_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_op        = r_op;
        n_key       = r_key;
        n_idx       = r_idx;
        n_sh        = r_sh;
        n_count     = r_count;
        n_present   = r_present;
        n_ok        = r_ok;
        n_full      = r_full;
        n_out_valid = r_out_valid && i_stall;
        n_out_ok    = r_out_ok;
        n_out_full  = r_out_full;
        n_out_count = r_out_count;
        rd_en       = 1'b0;
        rd_addr     = r_idx[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_sh;
        wr_data     = r_rd_data;
        case (r_state)
            sst_pkg::ST_IDLE: begin
                if (accept) begin
                    n_op      = sst_pkg::t_op'(i_op);
                    n_key     = i_key;
                    n_idx     = '0;
                    n_present = 1'b0;
                    n_ok      = 1'b0;
                    n_full    = 1'b0;
                end
            end
            sst_pkg::ST_SEARCH: begin
                if (r_idx != r_count) begin
                    rd_en = 1'b1;
                end
            end
            sst_pkg::ST_CMP: begin
                if (key_lt) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_present = key_eq;
                end
            end
            sst_pkg::ST_DECIDE: begin
                case (r_op)
                    sst_pkg::OP_INSERT: begin
                        n_sh = r_count[IW-1:0];
                        if (!r_present && table_at_cap) begin
                            n_full = 1'b1;
                        end
                    end
                    sst_pkg::OP_REMOVE: begin
                        n_sh = r_idx[IW-1:0];
                    end
                    sst_pkg::OP_CONTAINS: begin
                        n_ok = r_present;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            sst_pkg::ST_INS_RD: begin
                if (r_sh == r_idx[IW-1:0]) begin
                    wr_en   = 1'b1;
                    wr_data = r_key;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_sh - IW'(1);
                end
            end
            sst_pkg::ST_INS_WR: begin
                wr_en = 1'b1;
                n_sh  = r_sh - IW'(1);
            end
            sst_pkg::ST_REM_RD: begin
                if (rem_last) begin
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_sh + IW'(1);
                end
            end
            sst_pkg::ST_REM_WR: begin
                wr_en = 1'b1;
                n_sh  = r_sh + IW'(1);
            end
            sst_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_full  = r_full;
                    n_out_count = r_count;
                end
            end
            default: begin
                n_ok = r_ok;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sst_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_sh        <= n_sh;
        r_present   <= n_present;
        r_ok        <= n_ok;
        r_full      <= n_full;
        r_out_ok    <= n_out_ok;
        r_out_full  <= n_out_full;
        r_out_count <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_stall       = r_state != sst_pkg::ST_IDLE;
    assign o_valid       = r_out_valid;
    assign o_success     = r_out_ok;
    assign o_table_full  = r_out_full;
    assign o_entry_count = r_out_count;

endmodule

// ----- design/sst_checker.sv -----
module sst_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic                         o_success,
    input logic                         o_table_full,
    input logic [sst_pkg::CNT_W-1:0]    o_entry_count
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_success)
            && $stable(o_table_full) && $stable(o_entry_count))
        else $error("stalled result changed");

    // Only one item is worked on at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after an accepted item");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= sst_pkg::CNT_W'(sst_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_full_no_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> !o_success)
        else $error("refused insert reported success");

    // A refusal for lack of room only happens at capacity.
    a_full_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> o_entry_count == sst_pkg::CNT_W'(sst_pkg::CAPACITY))
        else $error("table full flagged below capacity");

endmodule

bind sorted_set_table sst_checker u_sst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_success     (o_success),
    .o_table_full  (o_table_full),
    .o_entry_count (o_entry_count)
);

// ----- verif/tb_sorted_set_table.sv -----
`timescale 1ns / 1ps

module tb_sorted_set_table;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 2 * sst_pkg::CAPACITY + 20;
    localparam int MAX_PRINTED  = 50;
    localparam int KB           = sst_pkg::KEY_BITS;
    localparam int CB           = sst_pkg::CNT_W;

    typedef struct packed {
        logic          success;
        logic          table_full;
        logic [CB-1:0] entry_count;
    } t_set_reply;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic [1:0]    i_op    = sst_pkg::OP_NONE;
    logic [KB-1:0] i_key   = '0;
    logic          i_stall = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic          o_success;
    logic          o_table_full;
    logic [CB-1:0] o_entry_count;

    // Predicted contents of the set, kept in ascending order.
    logic [KB-1:0] held_keys[$];
    t_set_reply    pending_replies[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  tx_idle_en     = 1'b1;
    bit  rx_idle_en     = 1'b1;
    bit  rx_hold        = 1'b0;
    bit  rx_stalling    = 1'b0;
    int  rx_run_left    = 0;
    event hold_req;

    sorted_set_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_success     (o_success),
        .o_table_full  (o_table_full),
        .o_entry_count (o_entry_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_error(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    // Applies one request to the predicted set and returns the reply it should give.
    function automatic t_set_reply apply_request(sst_pkg::t_op op, logic [KB-1:0] key);
        int         pos;
        bit         present;
        t_set_reply reply;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < key)
            pos++;
        present = (pos < held_keys.size()) && (held_keys[pos] == key);
        reply = '0;
        case (op)
            sst_pkg::OP_INSERT: begin
                if (!present) begin
                    if (held_keys.size() >= sst_pkg::CAPACITY) begin
                        reply.table_full = 1'b1;
                    end else begin
                        held_keys.insert(pos, key);
                        reply.success = 1'b1;
                    end
                end
            end
            sst_pkg::OP_REMOVE: begin
                if (present) begin
                    held_keys.delete(pos);
                    reply.success = 1'b1;
                end
            end
            sst_pkg::OP_CONTAINS: reply.success = present;
            default: ;
        endcase
        reply.entry_count = CB'(held_keys.size());
        return reply;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Keys are drawn mostly from held keys, their neighbors and three small
    // clusters near zero, the midpoint and the top, so that hits are common.
    function automatic logic [KB-1:0] pick_key();
        int r;
        int sel;
        r = $urandom_range(0, 99);
        if (r < 35 && held_keys.size() > 0)
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        if (r < 45 && held_keys.size() > 0) begin
            if ($urandom_range(0, 1))
                return held_keys[$urandom_range(0, held_keys.size() - 1)] + KB'(1);
            else
                return held_keys[$urandom_range(0, held_keys.size() - 1)] - KB'(1);
        end
        if (r < 75) begin
            sel = $urandom_range(0, 191);
            if (sel < 64)
                return KB'(sel);
            else if (sel < 128)
                return 32'h8000_0000 + KB'(sel - 64);
            else
                return 32'hFFFF_FFFF - KB'(sel - 128);
        end
        return $urandom;
    endfunction

    function automatic sst_pkg::t_op pick_op(int ins_pct, int rem_pct, int con_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return sst_pkg::OP_INSERT;
        else if (r < ins_pct + rem_pct)
            return sst_pkg::OP_REMOVE;
        else if (r < ins_pct + rem_pct + con_pct)
            return sst_pkg::OP_CONTAINS;
        else
            return sst_pkg::OP_NONE;
    endfunction

    task automatic set_idling(bit tx_en, bit rx_en);
        tx_idle_en = tx_en;
        rx_idle_en = rx_en;
    endtask

    // Offers one item and returns right after the edge at which it is taken.
    task automatic send_request(sst_pkg::t_op op, logic [KB-1:0] key);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        do
            @(posedge i_clk);
        while (o_stall);
        pending_replies.insert(pending_replies.size(), apply_request(op, key));
    endtask

    task automatic check_reply();
        t_set_reply want;
        if (pending_replies.size() == 0) begin
            report_error($sformatf("unexpected result: success=%0b full=%0b count=%0d",
                                   o_success, o_table_full, o_entry_count));
            return;
        end
        want = pending_replies.pop_front();
        if (o_success !== want.success)
            report_error($sformatf("success: got %b, expected %b", o_success, want.success));
        if (o_table_full !== want.table_full)
            report_error($sformatf("table_full: got %b, expected %b",
                                   o_table_full, want.table_full));
        if (o_entry_count !== want.entry_count)
            report_error($sformatf("entry_count: got %0d, expected %0d",
                                   o_entry_count, want.entry_count));
    endtask

    // Result side: check on the sampled handshake, then choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            check_reply();
        if (rx_hold) begin
            i_stall <= 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_stalling = rx_idle_en && ($urandom_range(0, 2) == 0);
                rx_run_left = pick_gap() + 1;
            end
            rx_run_left--;
            i_stall <= rx_stalling;
        end
    end

    always begin
        @(hold_req);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic test_directed_cases();
        send_request(sst_pkg::OP_CONTAINS, 32'h0000_0000);
        send_request(sst_pkg::OP_REMOVE,   32'h0000_0005);
        send_request(sst_pkg::OP_NONE,     32'hFFFF_FFFF);
        send_request(sst_pkg::OP_INSERT,   32'h8000_0000);
        send_request(sst_pkg::OP_INSERT,   32'h0000_0000);
        send_request(sst_pkg::OP_INSERT,   32'hFFFF_FFFF);
        send_request(sst_pkg::OP_INSERT,   32'h0000_0000);
        send_request(sst_pkg::OP_INSERT,   32'h7FFF_FFFF);
        send_request(sst_pkg::OP_INSERT,   32'h5555_5555);
        send_request(sst_pkg::OP_INSERT,   32'hAAAA_AAAA);
        send_request(sst_pkg::OP_CONTAINS, 32'hFFFF_FFFF);
        send_request(sst_pkg::OP_CONTAINS, 32'h0000_0001);
        send_request(sst_pkg::OP_CONTAINS, 32'hFFFF_FFFE);
        send_request(sst_pkg::OP_NONE,     32'h5555_5555);
        // The smallest key sits in the first entry and has no predecessor.
        send_request(sst_pkg::OP_REMOVE,   32'h0000_0000);
        send_request(sst_pkg::OP_REMOVE,   32'h0000_0000);
        send_request(sst_pkg::OP_REMOVE,   32'hFFFF_FFFF);
        send_request(sst_pkg::OP_REMOVE,   32'h8000_0000);
        send_request(sst_pkg::OP_CONTAINS, 32'h8000_0000);
        send_request(sst_pkg::OP_INSERT,   32'h0000_0000);
        send_request(sst_pkg::OP_CONTAINS, 32'h0000_0000);
        send_request(sst_pkg::OP_REMOVE,   32'h0000_0000);
        send_request(sst_pkg::OP_CONTAINS, 32'h5555_5555);
    endtask

    task automatic test_fill_and_overflow();
        int i;
        while (held_keys.size() < sst_pkg::CAPACITY)
            send_request(sst_pkg::OP_INSERT, $urandom);
        for (i = 0; i < 6; i++)
            send_request(sst_pkg::OP_INSERT, $urandom);
        // Duplicates must not report a full table even though it is full.
        for (i = 0; i < 4; i++)
            send_request(sst_pkg::OP_INSERT,
                         held_keys[$urandom_range(0, held_keys.size() - 1)]);
        for (i = 0; i < 4; i++)
            send_request(sst_pkg::OP_CONTAINS, pick_key());
        send_request(sst_pkg::OP_REMOVE, held_keys[0]);
        send_request(sst_pkg::OP_INSERT, 32'h0000_0000);
        send_request(sst_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_request(sst_pkg::OP_REMOVE, held_keys[held_keys.size() - 1]);
        send_request(sst_pkg::OP_NONE, $urandom);
    endtask

    task automatic test_drain();
        int n;
        n = 0;
        while (held_keys.size() > 0) begin
            n++;
            if (n % 8 == 0)
                send_request(sst_pkg::OP_REMOVE, $urandom);
            else if (n % 5 == 0)
                send_request(sst_pkg::OP_CONTAINS, pick_key());
            else
                send_request(sst_pkg::OP_REMOVE,
                             held_keys[$urandom_range(0, held_keys.size() - 1)]);
        end
        send_request(sst_pkg::OP_REMOVE, pick_key());
        send_request(sst_pkg::OP_CONTAINS, pick_key());
    endtask

    task automatic test_input_backpressure();
        int i;
        set_idling(1'b0, 1'b0);
        ->hold_req;
        for (i = 0; i < 24; i++)
            send_request(pick_op(40, 30, 27), pick_key());
        set_idling(1'b1, 1'b1);
    endtask

    task automatic test_random_mix(int rounds);
        int round;
        int i;
        for (round = 0; round < rounds; round++) begin
            set_idling(round != 1, round != 2);
            for (i = 0; i < 180; i++)
                send_request(pick_op(65, 15, 17), pick_key());
            set_idling(round != 3, round != 1);
            for (i = 0; i < 150; i++)
                send_request(pick_op(15, 65, 17), pick_key());
        end
        set_idling(1'b1, 1'b1);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_fill_and_overflow();
        test_drain();
        test_input_backpressure();
        test_random_mix(5);
        i_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
